// ===== design/lower_triangle_prime_counter_assert.svh =====
// Assertion macros for the lower triangle prime counter top level.
`ifndef LOWER_TRIANGLE_PRIME_COUNTER_ASSERT_SVH
`define LOWER_TRIANGLE_PRIME_COUNTER_ASSERT_SVH

// Same-cycle implication, disabled while reset is held.
`define LTPC_ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("ltpc assertion failed");

// Next-cycle implication, disabled while reset is held.
`define LTPC_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("ltpc assertion failed");

`endif

// ===== design/ltpc_pkg.sv =====
// Types and constants shared by the lower triangle prime counter modules.
package ltpc_pkg;

    localparam int MAX_DIM = 256;
    localparam int VAL_W   = 32;
    localparam int ROW_W   = 8;
    localparam int COUNT_W = 15;
    localparam int DIV_W   = 16;
    localparam int SQ_W    = 32;

    // Bits of a non-negative value that the remainder unit walks through.
    localparam int MOD_STEPS = VAL_W - 1;
    localparam int STEP_W    = $clog2(MOD_STEPS);

    // Number of places below the diagonal; the count saturates there.
    localparam logic [COUNT_W-1:0] COUNT_LIMIT = COUNT_W'(MAX_DIM * (MAX_DIM - 1) / 2);

    localparam logic [DIV_W-1:0] FIRST_DIVISOR = DIV_W'(3);
    localparam logic [SQ_W-1:0]  FIRST_SQUARE  = SQ_W'(9);

    typedef struct packed {
        logic                   start;
        logic [MOD_STEPS-1:0]   dividend;
        logic [DIV_W-1:0]       divisor;
    } t_mod_ctrl;

    typedef struct packed {
        logic busy;
        logic done;
        logic rem_zero;
    } t_mod_stat;

endpackage

// ===== design/lower_triangle_prime_counter.sv =====
// Top level of the lower triangle prime counter: sequencer, count, output register and remainder unit.
//
//  channel   | dir | handshake                     | contents
//  s_axis    | in  | s_axis_tvalid / s_axis_tready | element, row, column, first flag
//  m_axis    | out | m_axis_tvalid / m_axis_tready | element echo, kept flag, prime count
//
// A word is rejected at once, with no trial division, when it lies on or above the diagonal,
// is negative, is below two or is even; two is kept at once. Other words try odd divisors,
// each needing a full 31-step bit-serial remainder in the shared remainder unit. A 31-bit
// prime near the top of the range tries about 23170 divisors.
// Reset is synchronous and active low; it clears the sequencer, the count and the output
// valid flag. A stalled output holds its word while the next input word is taken and
// worked on; the finished result then waits in the sequencer until the output frees up.
module lower_triangle_prime_counter (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [47:0] s_axis_tdata,  // element_value[31:0], row_index[39:32], col_index[47:40]
    input  logic        s_axis_tuser,  // first_element
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [47:0] m_axis_tdata,  // value_out[31:0], primes_so_far[46:32], zero pad
    output logic        m_axis_tuser   // kept
);

`include "lower_triangle_prime_counter_assert.svh"

    typedef enum logic [1:0] {
        S_IDLE,
        S_CHECK,
        S_DIV,
        S_FIN
    } t_state;

    t_state                             r_state;
    logic [ltpc_pkg::VAL_W-1:0]         r_value;
    logic [ltpc_pkg::ROW_W-1:0]         r_row;
    logic [ltpc_pkg::ROW_W-1:0]         r_col;
    logic                               r_first;
    logic                               r_prime;
    logic [ltpc_pkg::DIV_W-1:0]         r_div;
    logic [ltpc_pkg::SQ_W-1:0]          r_sq;
    logic [ltpc_pkg::COUNT_W-1:0]       r_count;
    logic                               r_out_valid;
    logic [ltpc_pkg::VAL_W-1:0]         r_out_value;
    logic                               r_out_kept;
    logic [ltpc_pkg::COUNT_W-1:0]       r_out_count;

    logic [ltpc_pkg::VAL_W-1:0]         in_value;
    logic [ltpc_pkg::ROW_W-1:0]         in_row;
    logic [ltpc_pkg::ROW_W-1:0]         in_col;
    logic                               in_accept;
    logic                               in_inside;
    logic                               in_reject;
    logic                               in_two;
    logic                               sq_over;
    logic                               out_free;
    logic [ltpc_pkg::COUNT_W-1:0]       count_base;
    logic [ltpc_pkg::COUNT_W-1:0]       n_count;
    logic [ltpc_pkg::SQ_W-1:0]          n_sq;
    ltpc_pkg::t_mod_ctrl                mod_ctrl;
    ltpc_pkg::t_mod_stat                mod_stat;

    assign in_value  = s_axis_tdata[31:0];
    assign in_row    = s_axis_tdata[39:32];
    assign in_col    = s_axis_tdata[47:40];
    assign in_accept = s_axis_tvalid && s_axis_tready;

    // An element counts only if it lies inside the matrix and strictly below the diagonal.
    assign in_inside = (int'(in_row) < ltpc_pkg::MAX_DIM) && (int'(in_col) < ltpc_pkg::MAX_DIM);

    // Quick answers that need no trial division: anything off the lower triangle, negative
    // values, zero and one, and even values other than two; two itself is kept as prime.
    assign in_two    = (in_value == ltpc_pkg::VAL_W'(2));
    assign in_reject = !in_inside || !(in_col < in_row) || in_value[ltpc_pkg::VAL_W-1]
                       || (in_value < ltpc_pkg::VAL_W'(2)) || (!in_two && !in_value[0]);

    // The loop runs while the divisor squared does not exceed the value; the square is
    // carried along as (d+2)^2 = d^2 + 4d + 4 so no multiplier is needed.
    assign sq_over = (r_sq > r_value);
    assign n_sq    = r_sq + {{(ltpc_pkg::SQ_W - ltpc_pkg::DIV_W - 2){1'b0}}, r_div, 2'b00}
                     + ltpc_pkg::SQ_W'(4);

    assign out_free = !r_out_valid || m_axis_tready;

    // The first element of a matrix clears the count before it is itself counted.
    assign count_base = r_first ? '0 : r_count;
    assign n_count    = (r_prime && (count_base < ltpc_pkg::COUNT_LIMIT)) ? count_base + 1'b1
                                                                          : count_base;

    assign mod_ctrl.start    = (r_state == S_CHECK) && !sq_over;
    assign mod_ctrl.dividend = r_value[ltpc_pkg::MOD_STEPS-1:0];
    assign mod_ctrl.divisor  = r_div;

    ltpc_mod_unit u_mod (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctrl  (mod_ctrl),
        .o_stat  (mod_stat)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            // A finished result loads the output register; otherwise a taken word leaves it.
            if ((r_state == S_FIN) && out_free) begin
                r_out_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (in_accept) begin
                        r_value <= in_value;
                        r_row   <= in_row;
                        r_col   <= in_col;
                        r_first <= s_axis_tuser;
                        r_div   <= ltpc_pkg::FIRST_DIVISOR;
                        r_sq    <= ltpc_pkg::FIRST_SQUARE;
                        if (in_reject) begin
                            r_prime <= 1'b0;
                            r_state <= S_FIN;
                        end else if (in_two) begin
                            r_prime <= 1'b1;
                            r_state <= S_FIN;
                        end else begin
                            r_prime <= 1'b1;
                            r_state <= S_CHECK;
                        end
                    end
                end
                S_CHECK: begin
                    // No divisor up to the square root divides the value: it is prime.
                    if (sq_over) begin
                        r_state <= S_FIN;
                    end else begin
                        r_state <= S_DIV;
                    end
                end
                S_DIV: begin
                    if (mod_stat.done) begin
                        if (mod_stat.rem_zero) begin
                            r_prime <= 1'b0;
                            r_state <= S_FIN;
                        end else begin
                            r_div   <= r_div + ltpc_pkg::DIV_W'(2);
                            r_sq    <= n_sq;
                            r_state <= S_CHECK;
                        end
                    end
                end
                S_FIN: begin
                    if (out_free) begin
                        r_count     <= n_count;
                        r_out_value <= r_value;
                        r_out_kept  <= r_prime;
                        r_out_count <= n_count;
                        r_state     <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign s_axis_tready = (r_state == S_IDLE);
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {1'b0, r_out_count, r_out_value};
    assign m_axis_tuser  = r_out_kept;

    // Once a word is taken, the block is busy for at least the next cycle.
    `LTPC_ASSERT_NEXT(a_busy_after_accept, i_clk, i_rst_n, in_accept, !s_axis_tready)
    // The remainder unit only runs while the sequencer waits for it.
    `LTPC_ASSERT_SAME(a_mod_only_in_div, i_clk, i_rst_n, mod_stat.busy || mod_stat.done,
                      r_state == S_DIV)
    // The count never passes the number of places below the diagonal.
    `LTPC_ASSERT_SAME(a_count_limit, i_clk, i_rst_n, 1'b1,
                      r_count <= ltpc_pkg::COUNT_LIMIT)
    // A prime verdict is only ever reached for a non-negative value below the diagonal.
    `LTPC_ASSERT_SAME(a_prime_lower, i_clk, i_rst_n, (r_state == S_FIN) && r_prime,
                      (r_col < r_row) && !r_value[ltpc_pkg::VAL_W-1])

endmodule

// ===== design/ltpc_mod_unit.sv =====
// Bit-serial restoring remainder unit: one dividend bit per cycle.
module ltpc_mod_unit (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  ltpc_pkg::t_mod_ctrl i_ctrl,
    output ltpc_pkg::t_mod_stat o_stat
);

    logic                                r_busy;
    logic                                r_done;
    logic [ltpc_pkg::STEP_W-1:0]         r_cnt;
    logic [ltpc_pkg::MOD_STEPS-1:0]      r_shift;
    logic [ltpc_pkg::DIV_W-1:0]          r_rem;
    logic [ltpc_pkg::DIV_W:0]            trial;
    logic [ltpc_pkg::DIV_W:0]            diff;
    logic [ltpc_pkg::DIV_W-1:0]          n_rem;

    // Bring down the next dividend bit and subtract the divisor if it fits.
    assign trial = {r_rem, r_shift[ltpc_pkg::MOD_STEPS-1]};
    assign diff  = trial - {1'b0, i_ctrl.divisor};
    assign n_rem = (trial >= {1'b0, i_ctrl.divisor}) ? diff[ltpc_pkg::DIV_W-1:0]
                                                       : trial[ltpc_pkg::DIV_W-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_ctrl.start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == ltpc_pkg::STEP_W'(ltpc_pkg::MOD_STEPS - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctrl.start) begin
            r_shift <= i_ctrl.dividend;
            r_rem   <= '0;
        end else if (r_busy) begin
            r_shift <= {r_shift[ltpc_pkg::MOD_STEPS-2:0], 1'b0};
            r_rem   <= n_rem;
        end
    end

    assign o_stat.busy     = r_busy;
    assign o_stat.done     = r_done;
    assign o_stat.rem_zero = (r_rem == '0);

endmodule
